// File: rtl/core/q24alu_pkg.sv
package q24alu_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_W = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,  OP_SUB = 4'd1,  OP_MUL = 4'd2,  OP_DIV = 4'd3,
    OP_MIN = 4'd4,  OP_MAX = 4'd5,  OP_INC = 4'd6,  OP_DEC = 4'd7,
    OP_GT  = 4'd8,  OP_LT  = 4'd9,  OP_GE  = 4'd10, OP_LE  = 4'd11,
    OP_EQ  = 4'd12, OP_NE  = 4'd13, OP_I2F = 4'd14, OP_F2I = 4'd15
  } op_t;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               compare_true;
    logic               overflow;
    logic               div_by_zero;
  } rsp_t;

endpackage

// File: rtl/core/q24alu_div.sv
// pipelined restoring divider, one quotient bit per stage
// stage 0 registers the operands, then QW stages; the round-half test on the remainder is combinational
module q24alu_div #(
  parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num_mag,
  input  logic [31:0] den_mag,
  output logic [32+FRAC_BITS:0] quo,
  output logic        rem_ge_half
);
  localparam int QW = 32 + FRAC_BITS;
  localparam int RW = 34;

  logic [QW-1:0] n_r   [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [RW-1:0] rem_r [QW+1];
  logic [32:0]   d_r   [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= {num_mag, {FRAC_BITS{1'b0}}};
      q_r[0]   <= '0;
      rem_r[0] <= '0;
      d_r[0]   <= {1'b0, den_mag};
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [RW-1:0] sh;
    logic [RW-1:0] df;
    assign sh = {rem_r[s][RW-2:0], n_r[s][QW-1-s]};
    assign df = sh - {1'b0, d_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s+1] <= n_r[s];
        d_r[s+1] <= d_r[s];
        if (!df[RW-1]) begin
          rem_r[s+1] <= df;
          q_r[s+1]   <= {q_r[s][QW-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= sh;
          q_r[s+1]   <= {q_r[s][QW-2:0], 1'b0};
        end
      end
    end
  end

  // round half away: 2*rem >= den
  assign quo = {1'b0, q_r[QW]};
  assign rem_ge_half = ({rem_r[QW][RW-2:0], 1'b0} >= {1'b0, d_r[QW]});
endmodule

// File: rtl/core/q24_8_fixed_point_alu.sv
// channel | dir | ports                          | payload
// in      | in  | in_valid, in_ready, in_data    | q24alu_pkg::req_t
// out     | out | out_valid, out_ready, out_data | q24alu_pkg::rsp_t
// one transfer per cycle sustained while out is not stalled
// the depth is set by the divider, one quotient bit per stage
// every op rides the same pipe so results stay in order
// a stall on out freezes the whole pipe; in_ready is low only while out is full and stalled
// reset clears the valid bits only
module q24_8_fixed_point_alu #(
  parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  q24alu_pkg::req_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output q24alu_pkg::rsp_t    out_data
);
  localparam int QW = 32 + FRAC_BITS;
  localparam int LAT = QW + 1;
  localparam int PW = 65 + FRAC_BITS;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  logic [LAT:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-1:0], in_valid};
  end

  // stage 0: results other than divide and multiply, and the product
  q24alu_pkg::rsp_t s0_nxt;
  logic signed [63:0] prod_r;
  logic signed [31:0] a, b;
  logic signed [33:0] sum;
  logic signed [33:0] i2f;
  logic [3:0] op;
  assign a = in_data.operand_a;
  assign b = in_data.operand_b;
  assign op = in_data.req_type;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v,
                                               output logic ov);
    ov = (v > 34'sd2147483647) || (v < -34'sd2147483648);
    if (v > 34'sd2147483647) sat34 = 32'sh7fffffff;
    else if (v < -34'sd2147483648) sat34 = 32'sh80000000;
    else sat34 = v[31:0];
  endfunction

  always_comb begin
    logic ov;
    logic signed [31:0] r;
    logic signed [32+FRAC_BITS:0] sh;
    ov = 1'b0;
    r = '0;
    sum = '0;
    sh = {{(FRAC_BITS+1){a[31]}}, a} <<< FRAC_BITS;
    i2f = (sh > $signed({{(FRAC_BITS+1){1'b0}}, 32'h7fffffff})) ? 34'sd2147483648 :
          (sh < $signed({{(FRAC_BITS+1){1'b1}}, 32'h80000000})) ? -34'sd2147483649 :
          34'(sh);
    s0_nxt = '0;
    case (op)
      q24alu_pkg::OP_ADD: sum = 34'(a) + 34'(b);
      q24alu_pkg::OP_SUB: sum = 34'(a) - 34'(b);
      q24alu_pkg::OP_INC: sum = 34'(a) + 34'sd1;
      q24alu_pkg::OP_DEC: sum = 34'(a) - 34'sd1;
      q24alu_pkg::OP_I2F: sum = i2f;
      default: sum = '0;
    endcase
    r = sat34(sum, ov);
    case (op)
      q24alu_pkg::OP_MIN: begin r = (a > b) ? b : a; ov = 1'b0; end
      q24alu_pkg::OP_MAX: begin r = (a > b) ? a : b; ov = 1'b0; end
      q24alu_pkg::OP_F2I: begin r = a >>> FRAC_BITS; ov = 1'b0; end
      default: ;
    endcase
    case (op)
      q24alu_pkg::OP_GT: s0_nxt.compare_true = a > b;
      q24alu_pkg::OP_LT: s0_nxt.compare_true = a < b;
      q24alu_pkg::OP_GE: s0_nxt.compare_true = a >= b;
      q24alu_pkg::OP_LE: s0_nxt.compare_true = a <= b;
      q24alu_pkg::OP_EQ: s0_nxt.compare_true = a == b;
      q24alu_pkg::OP_NE: s0_nxt.compare_true = a != b;
      default: s0_nxt.compare_true = 1'b0;
    endcase
    if (op >= q24alu_pkg::OP_GT && op <= q24alu_pkg::OP_NE) begin
      r = '0; ov = 1'b0;
    end
    s0_nxt.result = r;
    s0_nxt.overflow = ov;
    s0_nxt.div_by_zero = (op == q24alu_pkg::OP_DIV) && (b == 0);
  end

  logic [31:0] amag, bmag;
  logic dneg;
  assign amag = a[31] ? 32'(-a) : 32'(a);
  assign bmag = b[31] ? 32'(-b) : 32'(b);
  assign dneg = a[31] ^ b[31];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(a) * 64'(b);
    end
  end

  // stage 1: rounded and saturated signed multiply result
  q24alu_pkg::rsp_t mul_r;
  always_ff @(posedge clk) begin
    logic [63:0] pm;
    logic [63:0] q;
    logic neg;
    logic signed [65:0] sv;
    logic ov;
    if (en) begin
      neg = prod_r[63];
      pm = neg ? 64'(-prod_r) : 64'(prod_r);
      q = (pm >> FRAC_BITS) + 64'(pm[FRAC_BITS-1]);
      sv = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
      ov = (sv > 66'sd2147483647) || (sv < -66'sd2147483648);
      mul_r.compare_true <= 1'b0;
      mul_r.div_by_zero <= 1'b0;
      mul_r.overflow <= ov;
      mul_r.result <= (sv > 66'sd2147483647) ? 32'sh7fffffff :
                      (sv < -66'sd2147483648) ? 32'sh80000000 : sv[31:0];
    end
  end

  // delay lines for the non-divide result, the op and the divide sign
  q24alu_pkg::rsp_t res_r [LAT];
  logic [3:0] op_r [LAT];
  logic neg_r [LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      res_r[0] <= s0_nxt;
      op_r[0]  <= op;
      neg_r[0] <= dneg;
      res_r[1] <= res_r[0];
      // mul_r lines up with the second delay stage
      res_r[2] <= (op_r[1] == q24alu_pkg::OP_MUL) ? mul_r : res_r[1];
      for (int i = 1; i < LAT; i++) begin
        if (i > 2) res_r[i] <= res_r[i-1];
        op_r[i]  <= op_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  logic [QW:0] quo;
  logic rhalf;
  q24alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .en(en), .num_mag(amag), .den_mag(bmag),
    .quo(quo), .rem_ge_half(rhalf)
  );

  // final stage: divide rounding and saturation
  q24alu_pkg::rsp_t out_r;
  always_ff @(posedge clk) begin
    logic [QW+1:0] qm;
    logic signed [QW+2:0] sv;
    if (en) begin
      qm = {1'b0, quo} + (QW+2)'(rhalf);
      sv = neg_r[LAT-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      out_r <= res_r[LAT-1];
      if (op_r[LAT-1] == q24alu_pkg::OP_DIV && !res_r[LAT-1].div_by_zero) begin
        out_r.overflow <= (sv > $signed((QW+3)'(32'h7fffffff))) ||
                          (sv < -$signed((QW+3)'(33'h080000000)));
        out_r.result <= (sv > $signed((QW+3)'(32'h7fffffff))) ? 32'sh7fffffff :
                        (sv < -$signed((QW+3)'(33'h080000000))) ? 32'sh80000000 :
                        sv[31:0];
      end
    end
  end

  assign out_valid = v_r[LAT];
  assign out_data = out_r;
endmodule
